// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/core/bqc_pkg.sv =====
package bqc_pkg;

  localparam int MAX_SECTIONS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int COEFS_PER_SEC = 5;
  localparam int COEF_W        = 16;
  localparam int COEF_FRAC     = 14;
  localparam int DELAY_W       = 32;
  localparam int NSEC_W        = 4;
  localparam int SEC_IN_W      = 3;
  localparam int SLOT_W        = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int PC_W          = 4;

  // input func codes
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_SECTIONS = 1'b0;
  localparam logic REG_GAIN         = 1'b1;

  // coefficient slots within a section
  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  // program addresses
  localparam logic [PC_W-1:0] STEP_GAIN_MUL = 4'd0;
  localparam logic [PC_W-1:0] STEP_GAIN_RND = 4'd1;
  localparam logic [PC_W-1:0] STEP_SEC_B0   = 4'd2;
  localparam logic [PC_W-1:0] STEP_SEC_Y    = 4'd3;
  localparam logic [PC_W-1:0] STEP_SEC_B2   = 4'd4;
  localparam logic [PC_W-1:0] STEP_SEC_A1   = 4'd5;
  localparam logic [PC_W-1:0] STEP_SEC_A2   = 4'd6;
  localparam logic [PC_W-1:0] STEP_SEC_WB   = 4'd7;
  localparam logic [PC_W-1:0] STEP_OUT      = 4'd8;

  typedef enum logic {MA_GAIN = 1'b0, MA_COEF = 1'b1} mul_a_t;
  typedef enum logic {MB_X = 1'b0, MB_Y = 1'b1} mul_b_t;

  typedef enum logic [2:0] {
    A1_HOLD  = 3'd0,
    A1_ZERO  = 3'd1,
    A1_LD_D1 = 3'd2,
    A1_LD_D2 = 3'd3,
    A1_ADD   = 3'd4,
    A1_SUB   = 3'd5
  } acc1_op_t;

  typedef enum logic {A2_HOLD = 1'b0, A2_LD_PROD = 1'b1} acc2_op_t;

  typedef enum logic [1:0] {
    JMP_NONE  = 2'd0,  // fall through
    JMP_NOSEC = 2'd1,  // skip to output when no section is in use
    JMP_LOOP  = 2'd2,  // next section or output
    JMP_DONE  = 2'd3   // hand result to output register, then idle
  } jump_t;

  // all-zero word is a no-op
  typedef struct packed {
    logic              mul_en;
    mul_a_t            mul_a;
    mul_b_t            mul_b;
    acc1_op_t          acc1_op;
    acc2_op_t          acc2_op;
    logic              rd_en;
    logic              rd_adv;   // read from next section's base
    logic [SLOT_W-1:0] rd_slot;
    logic              x_ld;     // x <= rounded value
    logic              y_ld;     // y <= rounded value
    logic              wb;       // write delays, x <= y, advance section
    jump_t             jump;
  } ctl_t;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '0;
    case (pc)
      STEP_GAIN_MUL: begin
        c.mul_en  = 1'b1;
        c.mul_a   = MA_GAIN;
        c.mul_b   = MB_X;
        c.acc1_op = A1_ZERO;
      end
      STEP_GAIN_RND: begin
        c.x_ld    = 1'b1;
        c.rd_en   = 1'b1;
        c.rd_slot = SLOT_B0;
        c.jump    = JMP_NOSEC;
      end
      STEP_SEC_B0: begin
        c.mul_en  = 1'b1;
        c.mul_a   = MA_COEF;
        c.mul_b   = MB_X;
        c.acc1_op = A1_LD_D1;
        c.rd_en   = 1'b1;
        c.rd_slot = SLOT_B1;
      end
      STEP_SEC_Y: begin
        c.y_ld    = 1'b1;
        c.mul_en  = 1'b1;
        c.mul_a   = MA_COEF;
        c.mul_b   = MB_X;
        c.acc1_op = A1_LD_D2;
        c.rd_en   = 1'b1;
        c.rd_slot = SLOT_B2;
      end
      STEP_SEC_B2: begin
        c.acc1_op = A1_ADD;
        c.mul_en  = 1'b1;
        c.mul_a   = MA_COEF;
        c.mul_b   = MB_X;
        c.rd_en   = 1'b1;
        c.rd_slot = SLOT_A1;
      end
      STEP_SEC_A1: begin
        c.acc2_op = A2_LD_PROD;
        c.mul_en  = 1'b1;
        c.mul_a   = MA_COEF;
        c.mul_b   = MB_Y;
        c.rd_en   = 1'b1;
        c.rd_slot = SLOT_A2;
      end
      STEP_SEC_A2: begin
        c.acc1_op = A1_SUB;
        c.mul_en  = 1'b1;
        c.mul_a   = MA_COEF;
        c.mul_b   = MB_Y;
      end
      STEP_SEC_WB: begin
        c.wb      = 1'b1;
        c.rd_en   = 1'b1;
        c.rd_adv  = 1'b1;
        c.rd_slot = SLOT_B0;
        c.jump    = JMP_LOOP;
      end
      STEP_OUT: begin
        c.jump = JMP_DONE;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/bqc_datapath.sv =====
module bqc_datapath #(
  parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_BITS  = bqc_pkg::SAMPLE_BITS_DEF,
  localparam int CDEPTH  = bqc_pkg::COEFS_PER_SEC * MAX_SECTIONS,
  localparam int CADDR_W = $clog2(CDEPTH),
  localparam int SEC_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bqc_pkg::ctl_t                        ctl,
  input  logic                                 start,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  input  logic signed [bqc_pkg::COEF_W-1:0]    gain,
  input  logic                                 coef_we,
  input  logic [CADDR_W-1:0]                   coef_waddr,
  input  logic signed [bqc_pkg::COEF_W-1:0]    coef_wdata,
  input  logic [CADDR_W-1:0]                   coef_raddr,
  input  logic [SEC_W-1:0]                     dly_idx,
  output logic signed [SAMPLE_BITS-1:0]        sample,
  output logic                                 sat
);

  localparam int PROD_W = bqc_pkg::COEF_W + SAMPLE_BITS;
  localparam int ACC_W  = ((PROD_W > bqc_pkg::DELAY_W) ? PROD_W : bqc_pkg::DELAY_W) + 2;
  localparam int DW     = bqc_pkg::DELAY_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (bqc_pkg::COEF_FRAC - 1));
  localparam logic signed [ACC_W-1:0] S_MAX    = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_W-1:0] S_MIN    = -S_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] D_MAX    = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] D_MIN    = -D_MAX - ACC_W'(1);

  // coefficient store, reads as zero until an entry is written
  logic signed [bqc_pkg::COEF_W-1:0] coef_mem [CDEPTH];
  logic [CDEPTH-1:0]                 coef_vld_r;
  logic signed [bqc_pkg::COEF_W-1:0] coef_raw_r;
  logic                              coef_rd_vld_r;
  logic signed [bqc_pkg::COEF_W-1:0] coef;

  logic signed [DW-1:0] dly1_r [MAX_SECTIONS];
  logic signed [DW-1:0] dly2_r [MAX_SECTIONS];

  logic signed [SAMPLE_BITS-1:0] x_r, y_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc1_r, acc2_r;
  logic                          sat_r;

  logic signed [bqc_pkg::COEF_W-1:0] mul_a;
  logic signed [SAMPLE_BITS-1:0]     mul_b;
  logic signed [ACC_W-1:0]           prod_ext, d1_ext, d2_ext;
  logic signed [ACC_W-1:0]           rnd_sum, rnd_q, d2_sum;
  logic signed [SAMPLE_BITS-1:0]     rnd_val;
  logic                              rnd_clip;
  logic signed [DW-1:0]              d1_val, d2_val;
  logic                              d1_clip, d2_clip;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_raw_r    <= coef_mem[coef_raddr];
    coef_rd_vld_r <= coef_vld_r[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (coef_we) begin
      coef_vld_r[coef_waddr] <= 1'b1;
    end
  end

  assign coef = coef_rd_vld_r ? coef_raw_r : '0;

  assign mul_a = (ctl.mul_a == bqc_pkg::MA_GAIN) ? gain : coef;
  assign mul_b = (ctl.mul_b == bqc_pkg::MB_X) ? x_r : y_r;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign d1_ext   = {{(ACC_W-DW){dly1_r[dly_idx][DW-1]}}, dly1_r[dly_idx]};
  assign d2_ext   = {{(ACC_W-DW){dly2_r[dly_idx][DW-1]}}, dly2_r[dly_idx]};

  // round half up at the coefficient binary point, then clip to a sample
  always_comb begin
    rnd_sum  = acc1_r + prod_ext + RND_HALF;
    rnd_q    = rnd_sum >>> bqc_pkg::COEF_FRAC;
    rnd_clip = 1'b0;
    if (rnd_q > S_MAX) begin
      rnd_val  = S_MAX[SAMPLE_BITS-1:0];
      rnd_clip = 1'b1;
    end else if (rnd_q < S_MIN) begin
      rnd_val  = S_MIN[SAMPLE_BITS-1:0];
      rnd_clip = 1'b1;
    end else begin
      rnd_val = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    d2_sum  = acc2_r - prod_ext;
    d1_clip = 1'b0;
    d2_clip = 1'b0;
    if (acc1_r > D_MAX) begin
      d1_val  = D_MAX[DW-1:0];
      d1_clip = 1'b1;
    end else if (acc1_r < D_MIN) begin
      d1_val  = D_MIN[DW-1:0];
      d1_clip = 1'b1;
    end else begin
      d1_val = acc1_r[DW-1:0];
    end
    if (d2_sum > D_MAX) begin
      d2_val  = D_MAX[DW-1:0];
      d2_clip = 1'b1;
    end else if (d2_sum < D_MIN) begin
      d2_val  = D_MIN[DW-1:0];
      d2_clip = 1'b1;
    end else begin
      d2_val = d2_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (ctl.acc1_op)
      bqc_pkg::A1_HOLD:  acc1_r <= acc1_r;
      bqc_pkg::A1_ZERO:  acc1_r <= '0;
      bqc_pkg::A1_LD_D1: acc1_r <= d1_ext;
      bqc_pkg::A1_LD_D2: acc1_r <= d2_ext;
      bqc_pkg::A1_ADD:   acc1_r <= acc1_r + prod_ext;
      bqc_pkg::A1_SUB:   acc1_r <= acc1_r - prod_ext;
      default:           acc1_r <= acc1_r;
    endcase
    if (ctl.acc2_op == bqc_pkg::A2_LD_PROD) begin
      acc2_r <= prod_ext;
    end
    if (start) begin
      x_r <= sample_in;
    end else if (ctl.x_ld) begin
      x_r <= rnd_val;
    end else if (ctl.wb) begin
      x_r <= y_r;
    end
    if (ctl.y_ld) begin
      y_r <= rnd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        dly1_r[i] <= '0;
        dly2_r[i] <= '0;
      end
    end else if (ctl.wb) begin
      dly1_r[dly_idx] <= d1_val;
      dly2_r[dly_idx] <= d2_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (start) begin
      sat_r <= 1'b0;
    end else begin
      sat_r <= sat_r | ((ctl.x_ld | ctl.y_ld) & rnd_clip) | (ctl.wb & (d1_clip | d2_clip));
    end
  end

  assign sample = x_r;
  assign sat    = sat_r;

endmodule

// ===== rtl/core/biquad_cascade_filter_top.sv =====
// Channel   Handshake            Payload
// input     in_valid/in_stall    in_func, in_sample_in, in_coef_section, in_coef_slot,
//                                in_coef_value
// output    out_valid/out_stall  out_sample_out, out_saturated
// config    APB psel/penable     paddr, pwdata, prdata (num_sections @0, gain @4)
//
// Sample: gain multiply and round steps, then B0, Y, B2, A1, A2 and WB per
// section in use (capped at MAX_SECTIONS), then the output step; every product
// comes from the single shared coefficient x sample multiplier.
// Coefficient write: no result.
// in_stall is high while a sample is in work; a full, stalled output register holds
// the sequencer at its last step, so the next item waits.
// Reset: one section, unity gain, delays cleared, coefficients read as zero.
`include "assert_macros.svh"

module biquad_cascade_filter_top #(
  parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_BITS  = bqc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_func,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_in,
  input  logic [bqc_pkg::SEC_IN_W-1:0]           in_coef_section,
  input  logic [bqc_pkg::SLOT_W-1:0]             in_coef_slot,
  input  logic signed [bqc_pkg::COEF_W-1:0]      in_coef_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]          out_sample_out,
  output logic                                   out_saturated,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bqc_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [bqc_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int CDEPTH  = bqc_pkg::COEFS_PER_SEC * MAX_SECTIONS;
  localparam int CADDR_W = $clog2(CDEPTH);
  localparam int BASE_W  = $clog2(CDEPTH + 1);
  localparam int SEC_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W   = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                        state_r, state_nxt;
  logic [bqc_pkg::PC_W-1:0]          pc_r, pc_nxt;
  logic [CNT_W-1:0]                  sec_cnt_r;
  logic [BASE_W-1:0]                 base_r;
  logic [bqc_pkg::NSEC_W-1:0]        num_sections_r;
  logic signed [bqc_pkg::COEF_W-1:0] gain_r;
  logic                              out_valid_r;
  logic signed [SAMPLE_BITS-1:0]     out_sample_r;
  logic                              out_sat_r;

  bqc_pkg::ctl_t                     ctl;
  logic                              in_acc, start, coef_we, cfg_we;
  logic                              out_free, out_load, more_sec;
  logic [CNT_W-1:0]                  sec_count;
  logic [BASE_W-1:0]                 rd_base, rd_sum;
  logic [CADDR_W-1:0]                coef_waddr, coef_raddr;
  logic signed [SAMPLE_BITS-1:0]     dp_sample;
  logic                              dp_sat;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sections_r <= bqc_pkg::NSEC_W'(1);
      gain_r         <= bqc_pkg::COEF_W'(16384);
    end else if (cfg_we) begin
      if (paddr[2] == bqc_pkg::REG_NUM_SECTIONS) begin
        num_sections_r <= pwdata[bqc_pkg::NSEC_W-1:0];
      end else begin
        gain_r <= pwdata[bqc_pkg::COEF_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == bqc_pkg::REG_GAIN)
                ? {{(bqc_pkg::CFG_DATA_W - bqc_pkg::COEF_W){gain_r[bqc_pkg::COEF_W-1]}}, gain_r}
                : {{(bqc_pkg::CFG_DATA_W - bqc_pkg::NSEC_W){1'b0}}, num_sections_r};

  assign sec_count = (int'(num_sections_r) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                           : CNT_W'(num_sections_r);

  // input side
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign start    = in_acc & (in_func == bqc_pkg::FUNC_FILTER);
  assign coef_we  = in_acc & (in_func == bqc_pkg::FUNC_COEF)
                  & (in_coef_slot <= bqc_pkg::SLOT_A2)
                  & (int'(in_coef_section) < MAX_SECTIONS);
  assign coef_waddr = CADDR_W'(int'(in_coef_section) * bqc_pkg::COEFS_PER_SEC
                               + int'(in_coef_slot));

  // sequencer
  assign ctl = (state_r == ST_RUN) ? bqc_pkg::ucode(pc_r) : '0;

  assign rd_base    = ctl.rd_adv ? (base_r + BASE_W'(bqc_pkg::COEFS_PER_SEC)) : base_r;
  assign rd_sum     = rd_base + BASE_W'(ctl.rd_slot);
  assign coef_raddr = rd_sum[CADDR_W-1:0];

  assign more_sec = ((CNT_W+1)'(sec_cnt_r) + (CNT_W+1)'(1)) < (CNT_W+1)'(sec_count);
  assign out_free = ~out_valid_r | ~out_stall;
  assign out_load = (ctl.jump == bqc_pkg::JMP_DONE) & out_free;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    if (start) begin
      state_nxt = ST_RUN;
      pc_nxt    = bqc_pkg::STEP_GAIN_MUL;
    end else if (state_r == ST_RUN) begin
      case (ctl.jump)
        bqc_pkg::JMP_NONE: begin
          pc_nxt = pc_r + bqc_pkg::PC_W'(1);
        end
        bqc_pkg::JMP_NOSEC: begin
          pc_nxt = (sec_count == '0) ? bqc_pkg::STEP_OUT : pc_r + bqc_pkg::PC_W'(1);
        end
        bqc_pkg::JMP_LOOP: begin
          pc_nxt = more_sec ? bqc_pkg::STEP_SEC_B0 : bqc_pkg::STEP_OUT;
        end
        bqc_pkg::JMP_DONE: begin
          if (out_free) begin
            state_nxt = ST_IDLE;
            pc_nxt    = bqc_pkg::STEP_GAIN_MUL;
          end
        end
        default: begin
          pc_nxt = pc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pc_r      <= bqc_pkg::STEP_GAIN_MUL;
      sec_cnt_r <= '0;
      base_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      if (start) begin
        sec_cnt_r <= '0;
        base_r    <= '0;
      end else if (ctl.wb) begin
        sec_cnt_r <= sec_cnt_r + CNT_W'(1);
        base_r    <= base_r + BASE_W'(bqc_pkg::COEFS_PER_SEC);
      end
    end
  end

  bqc_datapath #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .start      (start),
    .sample_in  (in_sample_in),
    .gain       (gain_r),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (in_coef_value),
    .coef_raddr (coef_raddr),
    .dly_idx    (sec_cnt_r[SEC_W-1:0]),
    .sample     (dp_sample),
    .sat        (dp_sat)
  );

  // output register frees the sequencer for the next transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= dp_sample;
      out_sat_r    <= dp_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  `ASSERT_PROP(a_pc_range, clk, rst_n, pc_r <= bqc_pkg::STEP_OUT)
  `ASSERT_PROP(a_sec_range, clk, rst_n, (state_r == ST_RUN) |-> (sec_cnt_r <= sec_count))
  `ASSERT_PROP(a_out_from_seq, clk, rst_n, $rose(out_valid_r) |-> $past(pc_r == bqc_pkg::STEP_OUT))
  `ASSERT_PROP(a_sample_starts, clk, rst_n, start |=> (state_r == ST_RUN))
  `ASSERT_NEVER(a_coef_we_busy, clk, rst_n, coef_we && (state_r == ST_RUN))

endmodule
